@@ rtl/core/bmp24_stream_decoder_top_defines.svh @@
// Assertion macros for the BMP stream decoder top level.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef BMP24_STREAM_DECODER_TOP_DEFINES_SVH
`define BMP24_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BMP24_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/bmp24_pkg.sv @@
// Shared types, constants and helpers for the BMP stream decoder.
// No dependencies; used by the interfaces and all decoder modules.
`timescale 1ns / 1ps

package bmp24_pkg;

    // Image size limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Counter widths follow the limits
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 12;
    localparam int HCNT_W   = 6;
    localparam int PHASE_W  = 2;

    // Header layout
    localparam logic [BYTE_W-1:0] MAGIC_B = 8'h42;
    localparam logic [BYTE_W-1:0] MAGIC_M = 8'h4D;
    localparam int FILE_HDR_BYTES = 14;
    localparam int INFO_BYTES     = 40;
    localparam int HDR_BYTES      = FILE_HDR_BYTES + INFO_BYTES;
    localparam int DEPTH_BITS     = 24;

    localparam logic [HCNT_W-1:0] POS_MAGIC0  = 6'd0;
    localparam logic [HCNT_W-1:0] POS_MAGIC1  = 6'd1;
    localparam logic [HCNT_W-1:0] POS_OFS_LO  = 6'd10;
    localparam logic [HCNT_W-1:0] POS_OFS_HI  = 6'd13;
    localparam logic [HCNT_W-1:0] POS_INFO_LO = 6'd14;
    localparam logic [HCNT_W-1:0] POS_INFO_HI = 6'd17;
    localparam logic [HCNT_W-1:0] POS_WID_LO  = 6'd18;
    localparam logic [HCNT_W-1:0] POS_WID_HI  = 6'd21;
    localparam logic [HCNT_W-1:0] POS_HGT_LO  = 6'd22;
    localparam logic [HCNT_W-1:0] POS_HGT_HI  = 6'd25;
    localparam logic [HCNT_W-1:0] POS_DEP_LO  = 6'd28;
    localparam logic [HCNT_W-1:0] POS_DEP_HI  = 6'd29;
    localparam logic [HCNT_W-1:0] POS_LAST    = 6'(HDR_BYTES - 1);

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PIXEL  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd2;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_PIXEL      = 3'd0;
    localparam status_t ST_BAD_MAGIC  = 3'd1;
    localparam status_t ST_BAD_INFO   = 3'd2;
    localparam status_t ST_BAD_DEPTH  = 3'd3;
    localparam status_t ST_BAD_OFFSET = 3'd4;
    localparam status_t ST_TOO_LARGE  = 3'd5;

    // One result item
    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [IDX_W-1:0]  column;
        logic [IDX_W-1:0]  row_index;
        logic              last_pixel;
    } result_t;

    // Replace one byte lane of a little-endian word
    function automatic logic [31:0] put_byte(
        input logic [31:0]       word,
        input logic [BYTE_W-1:0] b,
        input logic [1:0]        lane
    );
        logic [31:0] w;
        begin
            w = word;
            case (lane)
                2'd0:    w[7:0]   = b;
                2'd1:    w[15:8]  = b;
                2'd2:    w[23:16] = b;
                default: w[31:24] = b;
            endcase
            return w;
        end
    endfunction

endpackage

@@ rtl/core/bmp24_in_if.sv @@
// Byte input channel of the BMP stream decoder: valid/ready plus file byte.
// Depends on bmp24_pkg for field widths.
`timescale 1ns / 1ps

interface bmp24_in_if;
    logic                           valid;
    logic                           ready;
    logic [bmp24_pkg::BYTE_W-1:0]   in_byte;
    logic                           start_of_file;

    modport source (output valid, output in_byte, output start_of_file, input ready);
    modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

@@ rtl/core/bmp24_out_if.sv @@
// Result channel of the BMP stream decoder: valid/ready plus pixel or error.
// Depends on bmp24_pkg for field widths.
`timescale 1ns / 1ps

interface bmp24_out_if;
    logic                           valid;
    logic                           ready;
    logic [bmp24_pkg::STATUS_W-1:0] status;
    logic [bmp24_pkg::BYTE_W-1:0]   red;
    logic [bmp24_pkg::BYTE_W-1:0]   green;
    logic [bmp24_pkg::BYTE_W-1:0]   blue;
    logic [bmp24_pkg::IDX_W-1:0]    column;
    logic [bmp24_pkg::IDX_W-1:0]    row_index;
    logic                           last_pixel;

    modport source (output valid, output status, output red, output green, output blue,
                    output column, output row_index, output last_pixel, input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    input column, input row_index, input last_pixel, output ready);
endinterface

@@ rtl/core/bmp24_stream_decoder_top.sv @@
// Channel     | Dir | Contents
// ------------+-----+----------------------------------------------------------
// byte_in     | in  | in_byte, start_of_file: one BMP file byte per transfer
// pixel_out   | out | status, red, green, blue, column, row_index, last_pixel
//
// One byte is taken per cycle while byte_in is ready; the parser is combinational and
// its result is registered in the output register, or in the skid entry if that is held.
// A skid entry keeps byte_in ready while one result waits on pixel_out; it
// drops ready only when both entries are full. Reset (rst_n low) returns the
// parser to the header phase and empties the output buffer.
// Depends on bmp24_pkg, bmp24_in_if, bmp24_out_if, bmp24_parse, bmp24_obuf.
`timescale 1ns / 1ps
`include "bmp24_stream_decoder_top_defines.svh"

module bmp24_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    bmp24_in_if.sink    byte_in,
    bmp24_out_if.source pixel_out
);

    logic                              fire;
    logic                              space;
    logic                              res_valid;
    bmp24_pkg::result_t                res;
    bmp24_pkg::result_t                out_data;
    logic [bmp24_pkg::PHASE_W-1:0]     phase;

    // Byte transfer
    assign fire          = byte_in.valid && byte_in.ready;
    assign byte_in.ready = space;

    bmp24_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (fire),
        .in_byte       (byte_in.in_byte),
        .start_of_file (byte_in.start_of_file),
        .res_valid     (res_valid),
        .res           (res),
        .phase         (phase)
    );

    bmp24_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (pixel_out.valid),
        .out_ready (pixel_out.ready),
        .out_data  (out_data)
    );

    // Drive the result channel
    assign pixel_out.status     = out_data.status;
    assign pixel_out.red        = out_data.red;
    assign pixel_out.green      = out_data.green;
    assign pixel_out.blue       = out_data.blue;
    assign pixel_out.column     = out_data.column;
    assign pixel_out.row_index  = out_data.row_index;
    assign pixel_out.last_pixel = out_data.last_pixel;

    // Checks
    `BMP24_ASSERT_NOW(a_err_clean, res_valid && res.status != bmp24_pkg::ST_PIXEL, res.red == 8'd0 && res.column == 12'd0 && res.last_pixel == 1'b0, "error result carries pixel data")
    `BMP24_ASSERT_NOW(a_done_quiet, fire && !byte_in.start_of_file && phase == bmp24_pkg::PH_DONE, !res_valid, "result produced after parse finished")
    `BMP24_ASSERT_NEXT(a_res_lands, fire && res_valid, pixel_out.valid, "accepted result not presented")
    `BMP24_ASSERT_NOW(a_stall_full, !byte_in.ready, pixel_out.valid, "input stalled with empty output")

endmodule

@@ rtl/core/bmp24_parse.sv @@
// Header parser and pixel assembler: one file byte per transfer.
// Depends on bmp24_pkg; feeds its result into bmp24_obuf.
`timescale 1ns / 1ps

module bmp24_parse (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic [bmp24_pkg::BYTE_W-1:0]         in_byte,
    input  logic                                 start_of_file,
    output logic                                 res_valid,
    output bmp24_pkg::result_t                   res,
    output logic [bmp24_pkg::PHASE_W-1:0]        phase
);

    logic [bmp24_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [bmp24_pkg::HCNT_W-1:0]  hc_reg, hc_next;
    logic [31:0]                   offset_reg, offset_next;
    logic [31:0]                   info_reg, info_next;
    logic [31:0]                   width_reg, width_next;
    logic [31:0]                   height_reg, height_next;
    logic [15:0]                   depth_reg, depth_next;
    logic [bmp24_pkg::COL_W-1:0]   col_reg, col_next;
    logic [bmp24_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [1:0]                    bip_reg, bip_next;
    logic [1:0]                    pad_reg, pad_next;
    logic [bmp24_pkg::BYTE_W-1:0]  blue_reg, blue_next;
    logic [bmp24_pkg::BYTE_W-1:0]  green_reg, green_next;

    // Effective phase and header position after a possible restart
    logic [bmp24_pkg::PHASE_W-1:0] ph;
    logic [bmp24_pkg::HCNT_W-1:0]  k;
    logic [bmp24_pkg::HCNT_W-1:0]  k_plus;
    logic [31:0]                   off_upd, info_upd, wid_upd, hgt_upd, dep_wide;
    logic [15:0]                   dep_upd;
    logic [31:0]                   col_ext, row_ext, col_plus, row_plus;
    logic                          last;

    assign ph     = start_of_file ? bmp24_pkg::PH_HEADER : phase_reg;
    assign k      = start_of_file ? '0 : hc_reg;
    assign k_plus = k + 6'd1;

    // Header words with the current byte merged in
    assign off_upd  = bmp24_pkg::put_byte(offset_reg, in_byte, 2'(k - bmp24_pkg::POS_OFS_LO));
    assign info_upd = bmp24_pkg::put_byte(info_reg, in_byte, 2'(k - bmp24_pkg::POS_INFO_LO));
    assign wid_upd  = bmp24_pkg::put_byte(width_reg, in_byte, 2'(k - bmp24_pkg::POS_WID_LO));
    assign hgt_upd  = bmp24_pkg::put_byte(height_reg, in_byte, 2'(k - bmp24_pkg::POS_HGT_LO));
    assign dep_wide = bmp24_pkg::put_byte(32'(depth_reg), in_byte,
                                          2'(k - bmp24_pkg::POS_DEP_LO));
    assign dep_upd  = dep_wide[15:0];

    // Pixel position arithmetic
    assign col_ext  = 32'(col_reg);
    assign row_ext  = 32'(row_reg);
    assign col_plus = col_ext + 32'd1;
    assign row_plus = row_ext + 32'd1;
    assign last     = (col_plus == width_reg) && (row_plus == height_reg);

    assign phase = phase_reg;

    // Next state and result for one accepted byte
    always_comb
    begin
        bmp24_pkg::status_t err;
        err         = bmp24_pkg::ST_PIXEL;
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        offset_next = offset_reg;
        info_next   = info_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        bip_next    = bip_reg;
        pad_next    = pad_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (take)
        begin
            phase_next = ph;
            hc_next    = k;
            case (ph)
                bmp24_pkg::PH_HEADER:
                begin
                    // Magic check on the first two bytes
                    if ((k == bmp24_pkg::POS_MAGIC0 && in_byte != bmp24_pkg::MAGIC_B) ||
                        (k == bmp24_pkg::POS_MAGIC1 && in_byte != bmp24_pkg::MAGIC_M))
                    begin
                        err = bmp24_pkg::ST_BAD_MAGIC;
                    end
                    else
                    begin
                        // Latch little-endian header fields
                        if (k inside {[bmp24_pkg::POS_OFS_LO:bmp24_pkg::POS_OFS_HI]})
                            offset_next = off_upd;
                        else if (k inside {[bmp24_pkg::POS_INFO_LO:bmp24_pkg::POS_INFO_HI]})
                            info_next = info_upd;
                        else if (k inside {[bmp24_pkg::POS_WID_LO:bmp24_pkg::POS_WID_HI]})
                            width_next = wid_upd;
                        else if (k inside {[bmp24_pkg::POS_HGT_LO:bmp24_pkg::POS_HGT_HI]})
                            height_next = hgt_upd;
                        else if (k inside {[bmp24_pkg::POS_DEP_LO:bmp24_pkg::POS_DEP_HI]})
                            depth_next = dep_upd;

                        // Field checks, first failure wins
                        if (k == bmp24_pkg::POS_INFO_HI &&
                            info_upd != 32'(bmp24_pkg::INFO_BYTES))
                            err = bmp24_pkg::ST_BAD_INFO;
                        else if (k == bmp24_pkg::POS_DEP_HI)
                        begin
                            if (dep_upd != 16'(bmp24_pkg::DEPTH_BITS))
                                err = bmp24_pkg::ST_BAD_DEPTH;
                            else if (offset_reg != 32'(bmp24_pkg::HDR_BYTES))
                                err = bmp24_pkg::ST_BAD_OFFSET;
                            else if (width_reg > 32'(bmp24_pkg::MAX_WIDTH) ||
                                     height_reg > 32'(bmp24_pkg::MAX_HEIGHT))
                                err = bmp24_pkg::ST_TOO_LARGE;
                        end

                        // Advance; enter pixel data after the last header byte
                        if (err == bmp24_pkg::ST_PIXEL)
                        begin
                            hc_next = k_plus;
                            if (k == bmp24_pkg::POS_LAST)
                            begin
                                hc_next  = '0;
                                col_next = '0;
                                row_next = '0;
                                bip_next = 2'd0;
                                pad_next = 2'd0;
                                phase_next = (width_reg == 32'd0 || height_reg == 32'd0) ?
                                             bmp24_pkg::PH_DONE : bmp24_pkg::PH_PIXEL;
                            end
                        end
                    end

                    // Report a failed check once, then go quiet
                    if (err != bmp24_pkg::ST_PIXEL)
                    begin
                        res_valid  = 1'b1;
                        res.status = err;
                        phase_next = bmp24_pkg::PH_DONE;
                    end
                end

                bmp24_pkg::PH_PIXEL:
                begin
                    if (pad_reg != 2'd0)
                    begin
                        // Drop row padding
                        pad_next = pad_reg - 2'd1;
                    end
                    else
                    begin
                        case (bip_reg)
                            2'd0:
                            begin
                                blue_next = in_byte;
                                bip_next  = 2'd1;
                            end
                            2'd1:
                            begin
                                green_next = in_byte;
                                bip_next   = 2'd2;
                            end
                            default:
                            begin
                                // Third byte completes the pixel
                                bip_next       = 2'd0;
                                res_valid      = 1'b1;
                                res.status     = bmp24_pkg::ST_PIXEL;
                                res.red        = in_byte;
                                res.green      = green_reg;
                                res.blue       = blue_reg;
                                res.column     = col_ext[bmp24_pkg::IDX_W-1:0];
                                res.row_index  = row_ext[bmp24_pkg::IDX_W-1:0];
                                res.last_pixel = last;
                                if (col_plus >= width_reg)
                                begin
                                    col_next = '0;
                                    row_next = bmp24_pkg::ROW_W'(row_plus);
                                    // Stored rows are padded to 4 bytes: pad = width mod 4
                                    pad_next = width_reg[1:0];
                                end
                                else
                                begin
                                    col_next = bmp24_pkg::COL_W'(col_plus);
                                end
                                if (last)
                                    phase_next = bmp24_pkg::PH_DONE;
                            end
                        endcase
                    end
                end

                default:
                begin
                    // Done (and the unused code): ignore bytes
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bmp24_pkg::PH_HEADER;
            hc_reg     <= '0;
            offset_reg <= '0;
            info_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            bip_reg    <= 2'd0;
            pad_reg    <= 2'd0;
            blue_reg   <= '0;
            green_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            offset_reg <= offset_next;
            info_reg   <= info_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            bip_reg    <= bip_next;
            pad_reg    <= pad_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

endmodule

@@ rtl/core/bmp24_obuf.sv @@
// Result register with one skid entry between the parser and the output channel.
// Depends on bmp24_pkg for the result type.
`timescale 1ns / 1ps

module bmp24_obuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmp24_pkg::result_t push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output bmp24_pkg::result_t out_data
);

    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    bmp24_pkg::result_t main_reg, main_next;
    bmp24_pkg::result_t skid_reg, skid_next;
    logic               pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Move results between the output register and the skid entry
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Hold valid flags; payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ tb/bmp24_stream_decoder_top_test.sv @@
// Self-checking testbench for bmp24_stream_decoder_top: feeds whole BMP byte streams
// and checks every pixel or error transfer against a local decoder model.
// Depends on bmp24_pkg, bmp24_in_if, bmp24_out_if and the decoder RTL.
`timescale 1ns / 1ps

module bmp24_stream_decoder_top_test;

    // Byte positions in the 54-byte header (little-endian fields)
    localparam int OFS_AT  = 10;
    localparam int INFO_AT = 14;
    localparam int WID_AT  = 18;
    localparam int HGT_AT  = 22;
    localparam int DEP_AT  = 28;

    localparam logic [31:0] GOOD_INFO  = 32'(bmp24_pkg::INFO_BYTES);
    localparam logic [31:0] GOOD_OFS   = 32'(bmp24_pkg::HDR_BYTES);
    localparam logic [15:0] GOOD_DEPTH = 16'(bmp24_pkg::DEPTH_BITS);
    localparam int          NO_CUT     = -1;

    // Run control: the long hold is well below the idle limit
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 150;

    // One file to send: header fields, truncation, trailing bytes, typed error
    typedef struct packed {
        logic                sof0;
        logic [31:0]         w;
        logic [31:0]         h;
        logic [7:0]          m0;
        logic [7:0]          m1;
        logic [31:0]         info;
        logic [15:0]         depth;
        logic [31:0]         ofs;
        int                  cut;
        int                  tail;
        logic                typed;
        bmp24_pkg::status_t  tstat;
    } bmp_file_t;

    // One byte transfer, with the typed error status of its file if any
    typedef struct packed {
        logic [7:0]          b;
        logic                sof;
        logic                typed;
        bmp24_pkg::status_t  tstat;
    } feed_t;

    localparam int NUM_DIRECTED = 17;

    // sof0, width, height, magic, info, depth, offset, cut, tail, typed, status
    localparam bmp_file_t DIRECTED_FILES [NUM_DIRECTED] = '{
        '{1'b0, 32'd1, 32'd1, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 0, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd2, 32'd2, 8'h00, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, 2, 0, 1'b1, bmp24_pkg::ST_BAD_MAGIC},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, 8'hFF, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, 3, 0, 1'b1, bmp24_pkg::ST_BAD_MAGIC},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, 32'd12,
          GOOD_DEPTH, GOOD_OFS, 20, 0, 1'b1, bmp24_pkg::ST_BAD_INFO},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, 32'hFFFF_FFFF,
          GOOD_DEPTH, GOOD_OFS, 18, 0, 1'b1, bmp24_pkg::ST_BAD_INFO},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          16'd32, 32'd0, 31, 0, 1'b1, bmp24_pkg::ST_BAD_DEPTH},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, 32'd55, 31, 0, 1'b1, bmp24_pkg::ST_BAD_OFFSET},
        '{1'b1, 32'd4097, 32'd1, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, 31, 0, 1'b1, bmp24_pkg::ST_TOO_LARGE},
        '{1'b1, 32'd1, 32'hFFFF_FFFF, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, 31, 0, 1'b1, bmp24_pkg::ST_TOO_LARGE},
        '{1'b1, 32'd4096, 32'd0, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 5, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd0, 32'd4096, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 0, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd3, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 6, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd2, 32'd3, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, 60, 0, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd5, 32'd1, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 0, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd4, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 0, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd1, 32'd3, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 2, 1'b0, bmp24_pkg::ST_PIXEL},
        '{1'b1, 32'd2, 32'd2, bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO,
          GOOD_DEPTH, GOOD_OFS, NO_CUT, 0, 1'b0, bmp24_pkg::ST_PIXEL}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bmp24_in_if  byte_in ();
    bmp24_out_if pixel_out ();

    bmp24_stream_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .pixel_out (pixel_out)
    );

    feed_t              file_bytes [$];
    bmp24_pkg::result_t expected_pixels [$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;

    // Decoder model state, at its reset values
    logic [1:0]  pr_phase = bmp24_pkg::PH_HEADER;
    int          pr_pos   = 0;
    logic [31:0] pr_ofs   = '0;
    logic [31:0] pr_info  = '0;
    logic [31:0] pr_wid   = '0;
    logic [31:0] pr_hgt   = '0;
    logic [15:0] pr_depth = '0;
    logic [31:0] pr_col   = '0;
    logic [31:0] pr_row   = '0;
    logic [1:0]  pr_sub   = '0;
    logic [1:0]  pr_pad   = '0;
    logic [7:0]  pr_blue  = '0;
    logic [7:0]  pr_green = '0;

    always #5 clk = ~clk;

    // Advance the decoder model by one byte; return 1 when it yields a result
    function automatic logic decode_byte(input logic [7:0] b, input logic sof,
                                         output bmp24_pkg::result_t r);
        int                 k;
        logic               fail;
        logic               is_last;
        bmp24_pkg::status_t code;
        r = '0;
        fail = 1'b0;
        code = bmp24_pkg::ST_PIXEL;
        if (sof)
        begin
            pr_phase = bmp24_pkg::PH_HEADER;
            pr_pos   = 0;
            pr_ofs   = '0;
            pr_info  = '0;
            pr_wid   = '0;
            pr_hgt   = '0;
            pr_depth = '0;
            pr_col   = '0;
            pr_row   = '0;
            pr_sub   = '0;
            pr_pad   = '0;
            pr_blue  = '0;
            pr_green = '0;
        end
        if (pr_phase == bmp24_pkg::PH_HEADER)
        begin
            k = pr_pos;
            if ((k == 0 && b != bmp24_pkg::MAGIC_B) || (k == 1 && b != bmp24_pkg::MAGIC_M))
            begin
                fail = 1'b1;
                code = bmp24_pkg::ST_BAD_MAGIC;
            end
            else
            begin
                // latch the little-endian header fields
                if (k >= OFS_AT && k < OFS_AT + 4)
                    pr_ofs[8*(k-OFS_AT) +: 8] = b;
                else if (k >= INFO_AT && k < INFO_AT + 4)
                    pr_info[8*(k-INFO_AT) +: 8] = b;
                else if (k >= WID_AT && k < WID_AT + 4)
                    pr_wid[8*(k-WID_AT) +: 8] = b;
                else if (k >= HGT_AT && k < HGT_AT + 4)
                    pr_hgt[8*(k-HGT_AT) +: 8] = b;
                else if (k >= DEP_AT && k < DEP_AT + 2)
                    pr_depth[8*(k-DEP_AT) +: 8] = b;
                // only the first failing check is reported
                if (k == INFO_AT + 3 && pr_info != GOOD_INFO)
                begin
                    fail = 1'b1;
                    code = bmp24_pkg::ST_BAD_INFO;
                end
                else if (k == DEP_AT + 1)
                begin
                    fail = 1'b1;
                    if (pr_depth != GOOD_DEPTH)
                        code = bmp24_pkg::ST_BAD_DEPTH;
                    else if (pr_ofs != GOOD_OFS)
                        code = bmp24_pkg::ST_BAD_OFFSET;
                    else if (pr_wid > 32'(bmp24_pkg::MAX_WIDTH) ||
                             pr_hgt > 32'(bmp24_pkg::MAX_HEIGHT))
                        code = bmp24_pkg::ST_TOO_LARGE;
                    else
                        fail = 1'b0;
                end
            end
            if (fail)
            begin
                pr_phase = bmp24_pkg::PH_DONE;
                r.status = code;
                return 1'b1;
            end
            pr_pos++;
            if (pr_pos >= bmp24_pkg::HDR_BYTES)
            begin
                pr_pos = 0;
                pr_col = '0;
                pr_row = '0;
                pr_sub = '0;
                pr_pad = '0;
                pr_phase = (pr_wid == 0 || pr_hgt == 0) ? bmp24_pkg::PH_DONE
                                                        : bmp24_pkg::PH_PIXEL;
            end
            return 1'b0;
        end
        if (pr_phase == bmp24_pkg::PH_PIXEL)
        begin
            // drop row fill bytes, then collect blue and green
            if (pr_pad != 0)
            begin
                pr_pad--;
                return 1'b0;
            end
            if (pr_sub == 2'd0)
            begin
                pr_blue = b;
                pr_sub = 2'd1;
                return 1'b0;
            end
            if (pr_sub == 2'd1)
            begin
                pr_green = b;
                pr_sub = 2'd2;
                return 1'b0;
            end
            pr_sub = 2'd0;
            is_last = (pr_col + 1 == pr_wid) && (pr_row + 1 == pr_hgt);
            r.status     = bmp24_pkg::ST_PIXEL;
            r.red        = b;
            r.green      = pr_green;
            r.blue       = pr_blue;
            r.column     = pr_col[bmp24_pkg::IDX_W-1:0];
            r.row_index  = pr_row[bmp24_pkg::IDX_W-1:0];
            r.last_pixel = is_last;
            pr_col++;
            if (pr_col >= pr_wid)
            begin
                pr_col = '0;
                pr_row++;
                // a row holds 3*w bytes, so the fill to 4 is w mod 4
                pr_pad = pr_wid[1:0];
            end
            if (is_last)
                pr_phase = bmp24_pkg::PH_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expand one file description into byte transfers
    task automatic queue_file(input bmp_file_t f);
        logic [7:0] hdr [bmp24_pkg::HDR_BYTES];
        int         n;
        feed_t      item;
        for (int i = 0; i < bmp24_pkg::HDR_BYTES; i++)
            hdr[i] = 8'($urandom);
        hdr[0] = f.m0;
        hdr[1] = f.m1;
        for (int i = 0; i < 4; i++)
        begin
            hdr[OFS_AT + i]  = f.ofs[8*i +: 8];
            hdr[INFO_AT + i] = f.info[8*i +: 8];
            hdr[WID_AT + i]  = f.w[8*i +: 8];
            hdr[HGT_AT + i]  = f.h[8*i +: 8];
        end
        hdr[DEP_AT]     = f.depth[7:0];
        hdr[DEP_AT + 1] = f.depth[15:8];
        n = bmp24_pkg::HDR_BYTES + f.tail;
        if (!f.typed && f.w != 0 && f.h != 0 &&
            f.w <= 32'(bmp24_pkg::MAX_WIDTH) && f.h <= 32'(bmp24_pkg::MAX_HEIGHT))
            n += int'(f.h) * (3 * int'(f.w) + int'(f.w[1:0]));
        if (f.cut >= 0 && f.cut < n)
            n = f.cut;
        for (int i = 0; i < n; i++)
        begin
            item.b     = (i < bmp24_pkg::HDR_BYTES) ? hdr[i] : 8'($urandom);
            item.sof   = (i == 0) ? f.sof0 : 1'b0;
            item.typed = f.typed;
            item.tstat = f.tstat;
            file_bytes.push_back(item);
        end
    endtask

    // Compare one field and report a mismatch
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t pixel_out.%s mismatch: expected %0h, actual %0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Build the stimulus, then send it in bursts and wait for the results
    initial
    begin
        bmp_file_t          f;
        feed_t              item;
        bmp24_pkg::result_t res;
        int                 idx;
        int                 burst;
        int                 gap;
        int                 kind;
        int                 n;
        byte_in.valid         <= 1'b0;
        byte_in.in_byte       <= '0;
        byte_in.start_of_file <= 1'b0;

        // directed files first
        for (int i = 0; i < NUM_DIRECTED; i++)
            queue_file(DIRECTED_FILES[i]);

        // random files: mostly well-formed, some broken, truncated or noise
        n = file_bytes.size() + RANDOM_BYTES;
        while (file_bytes.size() < n)
        begin
            f = '{1'b1, 32'($urandom_range(1, 8)), 32'($urandom_range(1, 4)),
                  bmp24_pkg::MAGIC_B, bmp24_pkg::MAGIC_M, GOOD_INFO, GOOD_DEPTH, GOOD_OFS,
                  NO_CUT, $urandom_range(0, 3), 1'b0, bmp24_pkg::ST_PIXEL};
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                queue_file(f);
            end
            else if (kind < 70)
            begin
                f.cut = $urandom_range(1, 80);
                queue_file(f);
            end
            else if (kind < 85)
            begin
                f.cut = $urandom_range(30, 60);
                case ($urandom_range(0, 6))
                    0:
                    begin
                        do f.m0 = 8'($urandom); while (f.m0 == bmp24_pkg::MAGIC_B);
                        f.tstat = bmp24_pkg::ST_BAD_MAGIC;
                    end
                    1:
                    begin
                        do f.m1 = 8'($urandom); while (f.m1 == bmp24_pkg::MAGIC_M);
                        f.tstat = bmp24_pkg::ST_BAD_MAGIC;
                    end
                    2:
                    begin
                        f.info = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 80));
                        if (f.info == GOOD_INFO)
                            f.info = GOOD_INFO + 32'd1;
                        f.tstat = bmp24_pkg::ST_BAD_INFO;
                    end
                    3:
                    begin
                        f.depth = $urandom_range(0, 1) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 48));
                        if (f.depth == GOOD_DEPTH)
                            f.depth = GOOD_DEPTH + 16'd8;
                        f.tstat = bmp24_pkg::ST_BAD_DEPTH;
                    end
                    4:
                    begin
                        f.ofs = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 120));
                        if (f.ofs == GOOD_OFS)
                            f.ofs = GOOD_OFS + 32'd1;
                        f.tstat = bmp24_pkg::ST_BAD_OFFSET;
                    end
                    5:
                    begin
                        f.w = $urandom;
                        if (f.w <= 32'(bmp24_pkg::MAX_WIDTH))
                            f.w = f.w + 32'(bmp24_pkg::MAX_WIDTH) + 32'd1;
                        f.tstat = bmp24_pkg::ST_TOO_LARGE;
                    end
                    default:
                    begin
                        f.h = $urandom;
                        if (f.h <= 32'(bmp24_pkg::MAX_HEIGHT))
                            f.h = f.h + 32'(bmp24_pkg::MAX_HEIGHT) + 32'd1;
                        f.tstat = bmp24_pkg::ST_TOO_LARGE;
                    end
                endcase
                queue_file(f);
            end
            else if (kind < 92)
            begin
                if ($urandom_range(0, 1))
                begin
                    f.w = '0;
                    f.h = 32'($urandom_range(1, bmp24_pkg::MAX_HEIGHT));
                end
                else
                begin
                    f.w = 32'($urandom_range(1, bmp24_pkg::MAX_WIDTH));
                    f.h = '0;
                end
                queue_file(f);
            end
            else
            begin
                // loose bytes with an occasional restart mark
                repeat ($urandom_range(1, 20))
                begin
                    item.b     = 8'($urandom);
                    item.sof   = ($urandom_range(0, 15) == 0);
                    item.typed = 1'b0;
                    item.tstat = bmp24_pkg::ST_PIXEL;
                    file_bytes.push_back(item);
                end
            end
        end

        // hold off until reset is released
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // send in bursts with random gaps; predict on each transfer
        idx = 0;
        while (idx < file_bytes.size())
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < file_bytes.size())
            begin
                item = file_bytes[idx];
                byte_in.valid         <= 1'b1;
                byte_in.in_byte       <= item.b;
                byte_in.start_of_file <= item.sof;
                @(posedge clk);
                while (!byte_in.ready)
                    @(posedge clk);
                if (decode_byte(item.b, item.sof, res))
                begin
                    if (item.typed)
                    begin
                        res = '0;
                        res.status = item.tstat;
                    end
                    expected_pixels.push_back(res);
                end
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && idx < file_bytes.size())
            begin
                byte_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        byte_in.valid <= 1'b0;

        // drain outstanding results, then keep watching for strays
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Hold reset low at the start, then release it
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stall the result side in changing patterns, with one long hold
    initial
    begin
        int   cyc;
        int   hold_left;
        int   mode;
        int   mode_left;
        logic rdy;
        cyc = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        pixel_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            cyc++;
            if (cyc == HOLD_AT)
                hold_left = HOLD_CYCLES;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = (cyc % 4 == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            pixel_out.ready <= rdy;
            @(posedge clk);
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        bmp24_pkg::result_t want;
        if (rst_n && pixel_out.valid && pixel_out.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t pixel_out mismatch: expected no result, actual status %0d",
                         $time, pixel_out.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("status", 32'(want.status), 32'(pixel_out.status));
                check_field("red", 32'(want.red), 32'(pixel_out.red));
                check_field("green", 32'(want.green), 32'(pixel_out.green));
                check_field("blue", 32'(want.blue), 32'(pixel_out.blue));
                check_field("column", 32'(want.column), 32'(pixel_out.column));
                check_field("row_index", 32'(want.row_index), 32'(pixel_out.row_index));
                check_field("last_pixel", 32'(want.last_pixel), 32'(pixel_out.last_pixel));
            end
        end
    end

    // End the run when no transfer happens on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (byte_in.valid && byte_in.ready) || (pixel_out.valid && pixel_out.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bmp24_pkg.sv
rtl/core/bmp24_in_if.sv
rtl/core/bmp24_out_if.sv
rtl/core/bmp24_parse.sv
rtl/core/bmp24_obuf.sv
rtl/core/bmp24_stream_decoder_top.sv
tb/bmp24_stream_decoder_top_test.sv
